/* hdl/utf8_terminal_display_width_unit_macros.svh */
// Assertion macros for the UTF-8 display width unit.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef UTF8_TERMINAL_DISPLAY_WIDTH_UNIT_MACROS_SVH
`define UTF8_TERMINAL_DISPLAY_WIDTH_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define UTDW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define UTDW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/utdw_pkg.sv */
// Constants, types and decode functions for the UTF-8 display width unit.
// No dependencies; used by the top level.
package utdw_pkg;

  localparam logic [7:0]  CH_ESC      = 8'h1B;
  localparam logic [7:0]  CH_LBRACKET = 8'h5B;
  localparam logic [7:0]  CH_M        = 8'h6D;
  localparam logic [5:0]  CONT_MASK   = 6'h3F;

  localparam int unsigned CP_W        = 21;
  localparam int unsigned COL_W       = 16;
  localparam logic [COL_W-1:0] COL_MAX = 16'hFFFF;

  localparam logic [CP_W-1:0] CP_REPL   = 21'h0FFFD;
  localparam logic [CP_W-1:0] CP_ZWJ    = 21'h0200D;
  localparam logic [CP_W-1:0] VS_LO     = 21'h0FE00;
  localparam logic [CP_W-1:0] VS_HI     = 21'h0FE0F;
  localparam logic [CP_W-1:0] VS_SUP_LO = 21'hE0100;
  localparam logic [CP_W-1:0] VS_SUP_HI = 21'hE01EF;

  localparam int unsigned WIDE_N = 16;
  localparam logic [CP_W-1:0] WIDE_LO [WIDE_N] = '{
    21'h01100, 21'h02E80, 21'h0AC00, 21'h0F900, 21'h0FE10, 21'h0FE30,
    21'h0FF01, 21'h0FFE0, 21'h0231A, 21'h023E9, 21'h02600, 21'h02B50,
    21'h1F000, 21'h1F0A0, 21'h1F680, 21'h1F780
  };
  localparam logic [CP_W-1:0] WIDE_HI [WIDE_N] = '{
    21'h0115F, 21'h0A4CF, 21'h0D7A3, 21'h0FAFF, 21'h0FE19, 21'h0FE6F,
    21'h0FF60, 21'h0FFE6, 21'h0231B, 21'h023FA, 21'h027BF, 21'h02B55,
    21'h1F02F, 21'h1F64F, 21'h1F6FF, 21'h1FAFF
  };

  typedef struct packed {
    logic [CP_W-1:0] part;
    logic [1:0]      rem;
    logic [1:0]      cols;
  } dec_res_t;

  function automatic logic [1:0] cols_of(input logic [CP_W-1:0] cp);
    logic wide;
    logic [1:0] res;
    wide = 1'b0;
    for (int k = 0; k < WIDE_N; k++) begin
      if (cp >= WIDE_LO[k] && cp <= WIDE_HI[k]) begin
        wide = 1'b1;
      end
    end
    if (cp == CP_ZWJ || (cp >= VS_LO && cp <= VS_HI) ||
        (cp >= VS_SUP_LO && cp <= VS_SUP_HI)) begin
      res = 2'd0;
    end else if (wide) begin
      res = 2'd2;
    end else begin
      res = 2'd1;
    end
    return res;
  endfunction

  // One UTF-8 decode step: a continuation byte extends a pending code point; any
  // other byte closes a pending character as a replacement and starts anew.
  function automatic dec_res_t dec_byte(input logic [CP_W-1:0] part,
                                        input logic [1:0] rem,
                                        input logic [7:0] c);
    dec_res_t r;
    logic [1:0] extra;
    r.part = part;
    r.rem  = rem;
    r.cols = 2'd0;
    extra  = 2'd0;
    if (rem != 2'd0 && c[7:6] == 2'b10) begin
      r.part = {part[CP_W-7:0], c[5:0] & CONT_MASK};
      r.rem  = rem - 2'd1;
      if (r.rem == 2'd0) begin
        r.cols = cols_of(r.part);
        r.part = '0;
      end
    end else begin
      if (rem != 2'd0) begin
        extra  = cols_of(CP_REPL);
        r.rem  = 2'd0;
        r.part = '0;
      end
      if (c[7] == 1'b0) begin
        r.cols = extra + cols_of({13'd0, c});
      end else if (c[7:5] == 3'b110) begin
        r.part = {16'd0, c[4:0]};
        r.rem  = 2'd1;
        r.cols = extra;
      end else if (c[7:4] == 4'b1110) begin
        r.part = {17'd0, c[3:0]};
        r.rem  = 2'd2;
        r.cols = extra;
      end else if (c[7:3] == 5'b11110) begin
        r.part = {18'd0, c[2:0]};
        r.rem  = 2'd3;
        r.cols = extra;
      end else begin
        r.cols = extra + cols_of(CP_REPL);
      end
    end
    return r;
  endfunction

endpackage

/* hdl/utdw_in_if.sv */
// Input channel of the UTF-8 display width unit: one byte of a string per item.
// No dependencies.
interface utdw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source(output valid, output byte_in, output last_byte, input ready);
  modport sink(input valid, input byte_in, input last_byte, output ready);
endinterface

/* hdl/utdw_out_if.sv */
// Result channel of the UTF-8 display width unit: one column count per string.
// No dependencies.
interface utdw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] width;
  logic        saturated;

  modport source(output valid, output width, output saturated, input ready);
  modport sink(input valid, input width, input saturated, output ready);
endinterface

/* hdl/utf8_terminal_display_width_unit.sv */
// A result is registered in the output register when the held last byte advances.
// Throughput: one byte per cycle; the byte register feeds the decoder and state directly.
// The input stalls only when a finished result waits in the output register unread.
// Reset (rst_n low, synchronous) empties both registers and returns the escape filter,
// the UTF-8 decoder and the column count to the start of a string.
// Uses utdw_pkg, utdw_in_if, utdw_out_if and the assertion macro header.
`include "utf8_terminal_display_width_unit_macros.svh"

module utf8_terminal_display_width_unit
  import utdw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  utdw_in_if.sink     in_ch,
  utdw_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    PH_NORMAL = 3'b001,
    PH_ESC    = 3'b010,
    PH_SEQ    = 3'b100
  } phase_t;

  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic             in_last_r;
  logic             adv;

  phase_t           phase_r, phase_nxt;
  logic [CP_W-1:0]  part_r, part_nxt;
  logic [1:0]       rem_r, rem_nxt;
  logic [COL_W-1:0] total_r, total_nxt;
  logic             sat_r, sat_nxt;

  logic             out_vld_r;
  logic [COL_W-1:0] out_width_r;
  logic             out_sat_r;

  logic             take_pre, take_main, take_end;
  dec_res_t         d_pre, d_main, d_end;
  logic [CP_W-1:0]  part1, part2, part3;
  logic [1:0]       rem1, rem2, rem3;
  logic [1:0]       c_pre, c_main, c_end, c_flush;
  logic [3:0]       col_sum;
  logic [COL_W:0]   t_sum;
  logic             sat_hit;

  assign adv         = in_vld_r && (!in_last_r || !out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.byte_in;
      in_last_r <= in_ch.last_byte;
    end
  end

  always_comb begin
    unique case (phase_r)
      PH_NORMAL: phase_nxt = (in_byte_r == CH_ESC) ? PH_ESC : PH_NORMAL;
      PH_ESC: begin
        if (in_byte_r == CH_LBRACKET) begin
          phase_nxt = PH_SEQ;
        end else if (in_byte_r == CH_ESC) begin
          phase_nxt = PH_ESC;
        end else begin
          phase_nxt = PH_NORMAL;
        end
      end
      PH_SEQ:    phase_nxt = (in_byte_r == CH_M) ? PH_NORMAL : PH_SEQ;
      default:   phase_nxt = PH_NORMAL;
    endcase
  end

  // A held ESC that is not followed by '[' is decoded before the current byte.
  assign take_pre  = (phase_r == PH_ESC) && (in_byte_r != CH_LBRACKET);
  assign take_main = (phase_r != PH_SEQ) && (in_byte_r != CH_ESC) &&
                     !((phase_r == PH_ESC) && (in_byte_r == CH_LBRACKET));

  assign d_pre  = dec_byte(part_r, rem_r, CH_ESC);
  assign part1  = take_pre ? d_pre.part : part_r;
  assign rem1   = take_pre ? d_pre.rem : rem_r;
  assign c_pre  = take_pre ? d_pre.cols : 2'd0;

  assign d_main = dec_byte(part1, rem1, in_byte_r);
  assign part2  = take_main ? d_main.part : part1;
  assign rem2   = take_main ? d_main.rem : rem1;
  assign c_main = take_main ? d_main.cols : 2'd0;

  // At the end of a string a trailing ESC counts; a cut-short character is classed
  // by the bits gathered so far, or as a replacement if a trailing ESC closes it.
  assign take_end = in_last_r && (phase_nxt == PH_ESC);
  assign d_end    = dec_byte(part2, rem2, CH_ESC);
  assign part3    = take_end ? d_end.part : part2;
  assign rem3     = take_end ? d_end.rem : rem2;
  assign c_end    = take_end ? d_end.cols : 2'd0;
  assign c_flush  = (in_last_r && rem3 != 2'd0) ? cols_of(part3) : 2'd0;

  assign col_sum = {2'd0, c_pre} + {2'd0, c_main} + {2'd0, c_end} + {2'd0, c_flush};
  assign t_sum   = {1'b0, total_r} + {{(COL_W-3){1'b0}}, col_sum};
  assign sat_hit = t_sum >= {1'b0, COL_MAX};

  assign part_nxt  = part2;
  assign rem_nxt   = rem2;
  assign total_nxt = sat_hit ? COL_MAX : t_sum[COL_W-1:0];
  assign sat_nxt   = sat_r || sat_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      part_r  <= '0;
      rem_r   <= 2'd0;
      total_r <= '0;
      sat_r   <= 1'b0;
    end else if (adv) begin
      if (in_last_r) begin
        phase_r <= PH_NORMAL;
        part_r  <= '0;
        rem_r   <= 2'd0;
        total_r <= '0;
        sat_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        part_r  <= part_nxt;
        rem_r   <= rem_nxt;
        total_r <= total_nxt;
        sat_r   <= sat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last_r) begin
      out_width_r <= total_nxt;
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.width     = out_width_r;
  assign out_ch.saturated = out_sat_r;

  `UTDW_ASSERT_NOW(a_sat_width, out_vld_r && out_sat_r, out_width_r == COL_MAX,
                   "saturated result without full width")
  `UTDW_ASSERT_NOW(a_total_sat, total_r == COL_MAX, sat_r,
                   "count at ceiling without saturation flag")
  `UTDW_ASSERT_NOW(a_part_idle, rem_r == 2'd0, part_r == '0,
                   "partial code point left without pending bytes")
  `UTDW_ASSERT_NEXT(a_end_clear, adv && in_last_r,
                    total_r == '0 && rem_r == 2'd0 && phase_r == PH_NORMAL,
                    "state not cleared after end of string")

endmodule
